[src/pdgc_pkg.sv]
// Shared types, constants and tables for the Poisson-disk grid conflict check.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none
package pdgc_pkg;

	// Grid geometry and fixed-point format
	localparam int GRID_SIDE = 128;
	localparam int FRAC_BITS = 16;
	localparam int GS_LOG2   = $clog2(GRID_SIDE);
	localparam int NCELLS    = GRID_SIDE * GRID_SIDE;

	// Field widths
	localparam int CELL_W  = 14;
	localparam int COORD_W = FRAC_BITS + 1;
	localparam int SIZE_W  = FRAC_BITS;
	localparam int CS_W    = 16;
	localparam int RSQ_W   = 32;
	localparam int ROW_W   = CELL_W - GS_LOG2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// Datapath widths: magnitude of a coordinate difference, its square, a sum of two
	localparam int MAG_W = COORD_W + 1;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int D_W   = SQ_W + 1;

	// Common scale for distance squared (2*FRAC_BITS fraction bits) and radius (32)
	localparam int SH_D  = (2 * FRAC_BITS < 32) ? 32 - 2 * FRAC_BITS : 0;
	localparam int SH_R  = (2 * FRAC_BITS >= 32) ? 2 * FRAC_BITS - 32 : 0;
	localparam int CMP_W = (D_W + SH_D > RSQ_W + SH_R) ? D_W + SH_D : RSQ_W + SH_R;

	localparam logic [COORD_W-1:0] COORD_MAX = '1;

	// Neighbor slots
	localparam int NSLOTS = 20;
	localparam int SLOT_W = $clog2(NSLOTS + 1);
	localparam logic [SLOT_W-1:0] NO_SLOT   = SLOT_W'(NSLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NSLOTS - 1);

	localparam logic signed [2:0] SLOT_DR [NSLOTS] = '{
		-3'sd2, -3'sd2, -3'sd2, -3'sd1, -3'sd1, -3'sd1, -3'sd1, -3'sd1, 3'sd0, 3'sd0,
		3'sd0, 3'sd0, 3'sd1, 3'sd1, 3'sd1, 3'sd1, 3'sd1, 3'sd2, 3'sd2, 3'sd2};
	localparam logic signed [2:0] SLOT_DC [NSLOTS] = '{
		-3'sd1, 3'sd0, 3'sd1, -3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2, -3'sd2, -3'sd1,
		3'sd1, 3'sd2, -3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2, -3'sd1, 3'sd0, 3'sd1};

	// Cell index offset of a neighbor slot, modulo the index width
	function automatic logic [CELL_W-1:0] nb_offset(input logic [SLOT_W-1:0] s);
		int off;
		off = 0;
		if (int'(s) < NSLOTS) begin
			off = int'(SLOT_DR[s]) * GRID_SIDE + int'(SLOT_DC[s]);
		end
		return CELL_W'(off);
	endfunction

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_HIT      = 2'd1,
		ST_OCCUPIED = 2'd2,
		ST_BORDER   = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		OP_DART  = 1'b0,
		OP_COVER = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CELL_SIZE = 1'b0,
		REG_RADIUS_SQ = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic               occ;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} grid_word_t;

endpackage
`default_nettype wire

[src/pdgc_req_if.sv]
// Request channel: one dart or coverage item per handshake.
// Depends on pdgc_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pdgc_req_if;
	logic                         valid;
	logic                         ready;
	logic                         opcode;
	logic [pdgc_pkg::CELL_W-1:0]  cell_index;
	logic [pdgc_pkg::COORD_W-1:0] pos_x;
	logic [pdgc_pkg::COORD_W-1:0] pos_y;
	logic [pdgc_pkg::SIZE_W-1:0]  sub_size;

	modport source (output valid, opcode, cell_index, pos_x, pos_y, sub_size, input ready);
	modport sink   (input valid, opcode, cell_index, pos_x, pos_y, sub_size, output ready);
endinterface
`default_nettype wire

[src/pdgc_rsp_if.sv]
// Response channel: status and neighbor slot of one item.
// Depends on pdgc_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pdgc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [pdgc_pkg::SLOT_W-1:0] hit_slot;

	modport source (output valid, status, hit_slot, input ready);
	modport sink   (input valid, status, hit_slot, output ready);
endinterface
`default_nettype wire

[src/pdgc_cfg_if.sv]
// Configuration write channel: register index and write data.
// Depends on pdgc_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pdgc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [pdgc_pkg::CFG_IDX_W-1:0]  index;
	logic [pdgc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/poisson_disk_grid_conflict_check.sv]
// Top level of the Poisson-disk grid conflict check: sequencer, grid memory, shared multiplier.
// Depends on pdgc_pkg, pdgc_req_if, pdgc_rsp_if, pdgc_cfg_if.
`timescale 1ns / 1ps
`default_nettype none
// A 128x128 background grid holds at most one sample point per cell in an internal memory
// (occupied bit plus x/y). Opcode 0 throws a dart at an offset inside a cell, opcode 1 asks
// whether a subcell is still open; each item gives exactly one response item. After reset the
// block runs a clearing pass over the grid memory, one cell per cycle, with
// req.ready low; configuration writes are taken at any time but are meant for idle periods.
// An accepted item then goes to S_CENTER; for a border or occupied cell it goes straight on to
// S_DONE. Otherwise a dart passes S_POSX and S_POSY and a coverage test goes directly to the
// neighbor scan, which examines up to 20 neighbor slots (fewer on an early conflict): per
// slot the one shared multiplier squares the x difference in S_NBX and the y difference in
// S_NBY, while the single read port of the grid memory fetches the next neighbor, and a third
// state, S_NBC, sums and compares. The block takes a new item in the cycle after the
// previous response is loaded, even while that response waits at rsp.
module poisson_disk_grid_conflict_check (
	input  wire        clk,
	input  wire        arst_n,
	pdgc_req_if.sink   req,
	pdgc_rsp_if.source rsp,
	pdgc_cfg_if.sink   cfg
);

	typedef enum logic [8:0] {
		S_CLEAR  = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_CENTER = 9'b000000100,
		S_POSX   = 9'b000001000,
		S_POSY   = 9'b000010000,
		S_NBX    = 9'b000100000,
		S_NBY    = 9'b001000000,
		S_NBC    = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [pdgc_pkg::CS_W-1:0]  cell_size_q;
	logic [pdgc_pkg::RSQ_W-1:0] radius_sq_q;

	// captured item
	logic                            op_q;
	logic [pdgc_pkg::CELL_W-1:0]     n_q;
	logic [pdgc_pkg::COORD_W-1:0]    x_q;
	logic [pdgc_pkg::COORD_W-1:0]    y_q;
	logic [pdgc_pkg::SIZE_W-1:0]     ss_q;

	// working registers
	logic [pdgc_pkg::COORD_W-1:0]    px_q;
	logic [pdgc_pkg::COORD_W-1:0]    py_q;
	logic [pdgc_pkg::SLOT_W-1:0]     slot_q;
	logic                            occ_q;
	logic [pdgc_pkg::SQ_W-1:0]       sq_x_q;
	logic [pdgc_pkg::SQ_W-1:0]       sq_y_q;
	logic [pdgc_pkg::CELL_W-1:0]     clr_q;
	logic [1:0]                      fin_status_q;
	logic [pdgc_pkg::SLOT_W-1:0]     fin_slot_q;

	// response register
	logic                            rsp_valid_q;
	logic [1:0]                      rsp_status_q;
	logic [pdgc_pkg::SLOT_W-1:0]     rsp_slot_q;

	// grid memory
	pdgc_pkg::grid_word_t            grid_mem [pdgc_pkg::NCELLS];
	pdgc_pkg::grid_word_t            rd_q;
	pdgc_pkg::grid_word_t            wr_data;
	logic [pdgc_pkg::CELL_W-1:0]     wr_addr;
	logic [pdgc_pkg::CELL_W-1:0]     rd_addr;
	logic                            wr_en;
	logic                            rd_en;

	logic                            accept;
	logic                            rsp_load;
	logic [pdgc_pkg::ROW_W-1:0]      row;
	logic [pdgc_pkg::GS_LOG2-1:0]    col;
	logic                            border;
	logic [pdgc_pkg::MAG_W-1:0]      mult_a;
	logic [pdgc_pkg::MAG_W-1:0]      mult_b;
	logic [pdgc_pkg::SQ_W-1:0]       prod;
	logic [pdgc_pkg::SQ_W:0]         pos_sum;
	logic [pdgc_pkg::COORD_W-1:0]    pos_sat;
	logic [pdgc_pkg::MAG_W-1:0]      mag_x;
	logic [pdgc_pkg::MAG_W-1:0]      mag_y;
	logic [pdgc_pkg::D_W-1:0]        d_sum;
	logic [pdgc_pkg::CMP_W-1:0]      ds;
	logic [pdgc_pkg::CMP_W-1:0]      rs;
	logic                            hit;

	function automatic logic [pdgc_pkg::MAG_W-1:0] abs_diff(
		input logic [pdgc_pkg::MAG_W-1:0] a,
		input logic [pdgc_pkg::MAG_W-1:0] b
	);
		return (a >= b) ? a - b : b - a;
	endfunction

	// Farther of the two subcell edges along one axis (coverage), or the point itself (dart).
	// Max over four corners splits into max x term plus max y term.
	function automatic logic [pdgc_pkg::MAG_W-1:0] axis_mag(
		input logic                           is_cov,
		input logic [pdgc_pkg::COORD_W-1:0]   q,
		input logic [pdgc_pkg::COORD_W-1:0]   lo,
		input logic [pdgc_pkg::SIZE_W-1:0]    ss
	);
		logic [pdgc_pkg::MAG_W-1:0] m_lo;
		logic [pdgc_pkg::MAG_W-1:0] m_hi;
		m_lo = abs_diff(pdgc_pkg::MAG_W'(q), pdgc_pkg::MAG_W'(lo));
		m_hi = abs_diff(pdgc_pkg::MAG_W'(q), pdgc_pkg::MAG_W'(lo) + pdgc_pkg::MAG_W'(ss));
		return (is_cov && (m_hi > m_lo)) ? m_hi : m_lo;
	endfunction

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = rsp_status_q;
	assign rsp.hit_slot = rsp_slot_q;

	// row and column of the current cell (GRID_SIDE is a power of two)
	assign row = n_q[pdgc_pkg::CELL_W-1:pdgc_pkg::GS_LOG2];
	assign col = n_q[pdgc_pkg::GS_LOG2-1:0];
	assign border = ({1'b0, n_q} >= (pdgc_pkg::CELL_W + 1)'(pdgc_pkg::NCELLS)) ||
		(row < pdgc_pkg::ROW_W'(2)) ||
		((pdgc_pkg::ROW_W + 1)'(row) + (pdgc_pkg::ROW_W + 1)'(2) >=
			(pdgc_pkg::ROW_W + 1)'(pdgc_pkg::GRID_SIDE)) ||
		(col < pdgc_pkg::GS_LOG2'(2)) ||
		((pdgc_pkg::GS_LOG2 + 1)'(col) + (pdgc_pkg::GS_LOG2 + 1)'(2) >=
			(pdgc_pkg::GS_LOG2 + 1)'(pdgc_pkg::GRID_SIDE));

	// neighbor magnitudes from the fetched grid word
	assign mag_x = axis_mag(op_q, rd_q.x, px_q, ss_q);
	assign mag_y = axis_mag(op_q, rd_q.y, py_q, ss_q);

	// shared multiplier: cell position products, then squares of the differences
	always_comb begin
		case (state_q)
			S_POSX: begin
				mult_a = pdgc_pkg::MAG_W'(row);
				mult_b = pdgc_pkg::MAG_W'(cell_size_q);
			end
			S_POSY: begin
				mult_a = pdgc_pkg::MAG_W'(col);
				mult_b = pdgc_pkg::MAG_W'(cell_size_q);
			end
			S_NBY: begin
				mult_a = mag_y;
				mult_b = mag_y;
			end
			default: begin
				mult_a = mag_x;
				mult_b = mag_x;
			end
		endcase
	end
	assign prod = mult_a * mult_b;

	// stored coordinate = cell origin + offset, saturated
	always_comb begin
		pos_sum = (pdgc_pkg::SQ_W + 1)'(prod) +
			(pdgc_pkg::SQ_W + 1)'((state_q == S_POSX) ? x_q : y_q);
		pos_sat = (pos_sum > (pdgc_pkg::SQ_W + 1)'(pdgc_pkg::COORD_MAX)) ?
			pdgc_pkg::COORD_MAX : pos_sum[pdgc_pkg::COORD_W-1:0];
	end

	// distance and radius at one scale; dart conflicts below, coverage at or below
	assign d_sum = pdgc_pkg::D_W'(sq_x_q) + pdgc_pkg::D_W'(sq_y_q);
	assign ds    = pdgc_pkg::CMP_W'(d_sum) << pdgc_pkg::SH_D;
	assign rs    = pdgc_pkg::CMP_W'(radius_sq_q) << pdgc_pkg::SH_R;
	assign hit   = occ_q && ((op_q == pdgc_pkg::OP_COVER) ? (ds <= rs) : (ds < rs));

	// grid memory ports
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = req.cell_index;
		case (state_q)
			S_IDLE: begin
				rd_en   = accept;
				rd_addr = req.cell_index;
			end
			S_CENTER: begin
				rd_en   = 1'b1;
				rd_addr = n_q + pdgc_pkg::nb_offset('0);
			end
			S_NBY: begin
				rd_en   = 1'b1;
				rd_addr = n_q + pdgc_pkg::nb_offset(slot_q + pdgc_pkg::SLOT_W'(1));
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = n_q;
			end
		endcase
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			// dart survives the last slot: store the point
			wr_en   = (state_q == S_NBC) && !hit && (slot_q == pdgc_pkg::LAST_SLOT) &&
				(op_q == pdgc_pkg::OP_DART);
			wr_addr = n_q;
			wr_data = '{occ: 1'b1, x: px_q, y: py_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			grid_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= grid_mem[rd_addr];
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= pdgc_pkg::CS_W'(463);
			radius_sq_q <= pdgc_pkg::RSQ_W'(429497);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				pdgc_pkg::REG_CELL_SIZE: cell_size_q <= cfg.data[pdgc_pkg::CS_W-1:0];
				pdgc_pkg::REG_RADIUS_SQ: radius_sq_q <= cfg.data[pdgc_pkg::RSQ_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			slot_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + pdgc_pkg::CELL_W'(1);
					if (clr_q == pdgc_pkg::CELL_W'(pdgc_pkg::NCELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CENTER;
					end
				end
				S_CENTER: begin
					slot_q <= '0;
					if (border || rd_q.occ) begin
						state_q <= S_DONE;
					end else if (op_q == pdgc_pkg::OP_DART) begin
						state_q <= S_POSX;
					end else begin
						state_q <= S_NBX;
					end
				end
				S_POSX: state_q <= S_POSY;
				S_POSY: state_q <= S_NBX;
				S_NBX:  state_q <= S_NBY;
				S_NBY:  state_q <= S_NBC;
				S_NBC: begin
					if (hit || (slot_q == pdgc_pkg::LAST_SLOT)) begin
						state_q <= S_DONE;
					end else begin
						slot_q  <= slot_q + pdgc_pkg::SLOT_W'(1);
						state_q <= S_NBX;
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req.opcode;
			n_q  <= req.cell_index;
			x_q  <= req.pos_x;
			y_q  <= req.pos_y;
			ss_q <= req.sub_size;
		end
		case (state_q)
			S_CENTER: begin
				// coverage uses the absolute corner as given
				px_q <= x_q;
				py_q <= y_q;
				fin_slot_q <= pdgc_pkg::NO_SLOT;
				if (border) begin
					fin_status_q <= pdgc_pkg::ST_BORDER;
				end else if (rd_q.occ) begin
					fin_status_q <= pdgc_pkg::ST_OCCUPIED;
				end else begin
					fin_status_q <= pdgc_pkg::ST_OK;
				end
			end
			S_POSX: px_q <= pos_sat;
			S_POSY: py_q <= pos_sat;
			S_NBX: begin
				occ_q  <= rd_q.occ;
				sq_x_q <= prod;
			end
			S_NBY: sq_y_q <= prod;
			S_NBC: begin
				if (hit) begin
					fin_status_q <= pdgc_pkg::ST_HIT;
					fin_slot_q   <= slot_q;
				end
			end
			default: ;
		endcase
		if (rsp_load) begin
			rsp_status_q <= fin_status_q;
			rsp_slot_q   <= fin_slot_q;
		end
	end

	// an accepted item keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("req.ready high right after an accepted item");

	// slot counter stays within the neighbor table while scanning
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_NBX) || (state_q == S_NBY) || (state_q == S_NBC)) |->
			(slot_q <= pdgc_pkg::LAST_SLOT))
		else $error("neighbor slot out of range");

	// a conflict names a real slot, anything else reports no slot
	a_slot_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> ((rsp_status_q == pdgc_pkg::ST_HIT) ?
			(rsp_slot_q < pdgc_pkg::NO_SLOT) : (rsp_slot_q == pdgc_pkg::NO_SLOT)))
		else $error("hit_slot inconsistent with status");

	// the grid is written only by the clearing pass or a dart that passed every slot
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && (state_q != S_CLEAR)) |-> ((op_q == pdgc_pkg::OP_DART) && !occ_q ||
			(op_q == pdgc_pkg::OP_DART) && !hit))
		else $error("unexpected grid write");

endmodule
`default_nettype wire
